>>> design/cmh_pkg.sv
// Shared constants, state encoding and controller/datapath interface types.
package cmh_pkg;

	// Default sizes of the block.
	localparam int MAX_SENSORS_DEF = 32;
	localparam int TIME_BITS_DEF   = 48;
	localparam int COUNT_BITS_DEF  = 32;

	// Fixed field and register widths.
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_INDEX_W = 1;
	localparam int WINDOW_W    = 32;
	localparam int SCOUNT_W    = 6;
	localparam int INDEX_W     = 5;
	localparam int LEVEL_W     = 6;

	// Register indexes of the configuration port.
	localparam logic [CFG_INDEX_W-1:0] REG_TIME_WINDOW  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_SENSOR_COUNT = 1'b1;

	// Register values after reset.
	localparam logic [WINDOW_W-1:0] TIME_WINDOW_RST  = 32'd200;
	localparam logic [SCOUNT_W-1:0] SENSOR_COUNT_RST = 6'd24;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_INC_RD,
		ST_INC_WR,
		ST_SETTLE,
		ST_FCLOSE,
		ST_EMIT_RD,
		ST_EMIT_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_hit;
		logic apply_hit;
		logic take_bin;
		logic clear_group;
		logic mem_rd;
		logic mem_wr;
		logic sel_emit;
		logic emit_next;
		logic emit_done;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic fin;
		logic close_hit;
		logic final_pending;
		logic last_bin;
	} dp_status_t;

endpackage

>>> design/coincidence_multiplicity_histogram.sv
// Top level: hit input channel, histogram output channel and configuration port.
// A hit is captured, then evaluated; a hit that closes a group then reads and writes back its bin.
// A final hit then lets the group population settle and closes any pending group, then each bin is read
// from memory and then offered from the output register, where it is held while the output is stalled.
// No new hit is taken until the read-modify-write of the bin memory for the last one is done.
// Reset clears the group, marks every histogram bin empty and restores the registers.
module coincidence_multiplicity_histogram #(
	parameter int MAX_SENSORS = cmh_pkg::MAX_SENSORS_DEF,
	parameter int TIME_BITS   = cmh_pkg::TIME_BITS_DEF,
	parameter int COUNT_BITS  = cmh_pkg::COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [cmh_pkg::CFG_INDEX_W-1:0] wr_index,
	input  logic [cmh_pkg::CFG_DATA_W-1:0]  wr_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [TIME_BITS-1:0]            hit_time,
	input  logic [cmh_pkg::INDEX_W-1:0]     sensor_index,
	input  logic                            final_hit,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [cmh_pkg::LEVEL_W-1:0]     multiplicity_level,
	output logic [COUNT_BITS-1:0]           occurrence_count,
	output logic                            final_bin
);
	import cmh_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// Sequencing.
	cmh_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// Group tracking and histogram storage.
	cmh_datapath #(
		.MAX_SENSORS (MAX_SENSORS),
		.TIME_BITS   (TIME_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.wr_en              (wr_en),
		.wr_index           (wr_index),
		.wr_data            (wr_data),
		.hit_time           (hit_time),
		.sensor_index       (sensor_index),
		.final_hit          (final_hit),
		.cmd                (cmd),
		.status             (status),
		.multiplicity_level (multiplicity_level),
		.occurrence_count   (occurrence_count),
		.final_bin          (final_bin)
	);

endmodule

>>> design/cmh_datapath.sv
// Datapath: configuration, group state, hit evaluation and the histogram memory.
module cmh_datapath #(
	parameter int MAX_SENSORS = cmh_pkg::MAX_SENSORS_DEF,
	parameter int TIME_BITS   = cmh_pkg::TIME_BITS_DEF,
	parameter int COUNT_BITS  = cmh_pkg::COUNT_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [cmh_pkg::CFG_INDEX_W-1:0]    wr_index,
	input  logic [cmh_pkg::CFG_DATA_W-1:0]     wr_data,
	input  logic [TIME_BITS-1:0]               hit_time,
	input  logic [cmh_pkg::INDEX_W-1:0]        sensor_index,
	input  logic                               final_hit,
	input  cmh_pkg::ctrl_cmd_t                 cmd,
	output cmh_pkg::dp_status_t                status,
	output logic [cmh_pkg::LEVEL_W-1:0]        multiplicity_level,
	output logic [COUNT_BITS-1:0]              occurrence_count,
	output logic                               final_bin
);
	import cmh_pkg::*;

	localparam int AW = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
	localparam int CW = $clog2(MAX_SENSORS + 1);
	localparam int EW = (CW > SCOUNT_W) ? CW : SCOUNT_W;
	localparam int DW = (TIME_BITS > WINDOW_W) ? TIME_BITS : WINDOW_W;

	// Configuration registers.
	logic [WINDOW_W-1:0] window_q;
	logic [SCOUNT_W-1:0] scount_q;

	// Captured hit.
	logic [TIME_BITS-1:0] hit_time_q;
	logic [INDEX_W-1:0]   hit_idx_q;
	logic                 hit_fin_q;

	// Open group.
	logic [TIME_BITS-1:0]   start_q;
	logic [MAX_SENSORS-1:0] mask_q;
	logic                   open_q;
	logic [CW-1:0]          pop_q;
	logic [AW-1:0]          bin_q;

	// Histogram store with per-bin valid bits.
	logic [COUNT_BITS-1:0]  mem [MAX_SENSORS];
	logic [MAX_SENSORS-1:0] valid_q;
	logic [COUNT_BITS-1:0]  rd_data_q;
	logic                   rd_valid_q;
	logic [AW-1:0]          k_q;

	logic [CW-1:0]          n_eff;
	logic [EW-1:0]          scount_ext;
	logic [MAX_SENSORS-1:0] low_mask;
	logic [MAX_SENSORS-1:0] hit_bit;
	logic                   hit_ok;
	logic [TIME_BITS-1:0]   elapsed;
	logic                   far;
	logic [CW-1:0]          pop_m1;
	logic [AW-1:0]          rd_addr;
	logic [COUNT_BITS-1:0]  old_count;
	logic [COUNT_BITS-1:0]  new_count;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= TIME_WINDOW_RST;
			scount_q <= SENSOR_COUNT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_TIME_WINDOW:  window_q <= wr_data[WINDOW_W-1:0];
				REG_SENSOR_COUNT: scount_q <= wr_data[SCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective sensor count, clamped to 1..MAX_SENSORS.
	always_comb begin
		scount_ext = EW'(scount_q);
		if (scount_q == '0) begin
			n_eff = CW'(1);
		end else if (scount_ext > EW'(MAX_SENSORS)) begin
			n_eff = CW'(MAX_SENSORS);
		end else begin
			n_eff = CW'(scount_ext);
		end
	end

	// Sensors in range and the one-hot bit of the captured hit.
	always_comb begin
		for (int i = 0; i < MAX_SENSORS; i++) begin
			low_mask[i] = (i < int'(n_eff));
			hit_bit[i]  = (i == int'(hit_idx_q));
		end
	end

	assign hit_ok  = int'(hit_idx_q) < int'(n_eff);
	assign elapsed = hit_time_q - start_q;
	assign far     = DW'(elapsed) > DW'(window_q);
	assign pop_m1  = pop_q - CW'(1);

	// Capture an accepted hit.
	always_ff @(posedge clk) begin
		if (cmd.load_hit) begin
			hit_time_q <= hit_time;
			hit_idx_q  <= sensor_index;
			hit_fin_q  <= final_hit;
		end
	end

	// Group state: open, extend or restart on a hit; cleared at the final close.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			mask_q  <= '0;
			open_q  <= 1'b0;
		end else if (cmd.clear_group) begin
			start_q <= '0;
			mask_q  <= '0;
			open_q  <= 1'b0;
		end else if (cmd.apply_hit && hit_ok) begin
			if (!open_q || far) begin
				start_q <= hit_time_q;
				mask_q  <= hit_bit;
				open_q  <= 1'b1;
			end else begin
				mask_q <= mask_q | hit_bit;
			end
		end
	end

	// Population of the in-range mask bits, registered, so it follows the mask in the next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_q <= '0;
		end else begin
			pop_q <= CW'($countones(mask_q & low_mask));
		end
	end

	// Bin selected by the group being closed.
	always_ff @(posedge clk) begin
		if (cmd.take_bin) begin
			bin_q <= pop_m1[AW-1:0];
		end
	end

	// Histogram memory: registered read, single write port.
	assign rd_addr = cmd.sel_emit ? k_q : bin_q;

	always_ff @(posedge clk) begin
		if (cmd.mem_rd) begin
			rd_data_q <= mem[rd_addr];
		end
		if (cmd.mem_wr) begin
			mem[bin_q] <= new_count;
		end
	end

	// A bin not written since the last clear reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (cmd.mem_rd) begin
				rd_valid_q <= valid_q[rd_addr];
			end
			if (cmd.emit_done) begin
				valid_q <= '0;
			end else if (cmd.mem_wr) begin
				valid_q[bin_q] <= 1'b1;
			end
		end
	end

	// Saturating increment.
	assign old_count = rd_valid_q ? rd_data_q : '0;
	assign new_count = (&old_count) ? old_count : old_count + COUNT_BITS'(1);

	// Emission bin counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (cmd.emit_done) begin
			k_q <= '0;
		end else if (cmd.emit_next) begin
			k_q <= k_q + AW'(1);
		end
	end

	// Status towards the controller.
	assign status.fin           = hit_fin_q;
	assign status.close_hit     = hit_ok && open_q && far && (pop_q != '0);
	assign status.final_pending = open_q && (pop_q != '0);
	assign status.last_bin      = (CW'(k_q) + CW'(1)) == n_eff;

	// Result payload.
	assign multiplicity_level = LEVEL_W'(k_q) + LEVEL_W'(1);
	assign occurrence_count   = old_count;
	assign final_bin          = status.last_bin;

endmodule

>>> design/cmh_controller.sv
// Controller: sequences hit evaluation, bin updates, the final close and emission.
module cmh_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  cmh_pkg::dp_status_t status,
	output cmh_pkg::ctrl_cmd_t  cmd
);
	import cmh_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   closed_q;

	// State register and the flag that the final close has been done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			closed_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				closed_q <= 1'b0;
			end else if (state_q == ST_FCLOSE) begin
				closed_q <= 1'b1;
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (status.close_hit)  state_d = ST_INC_RD;
				else if (status.fin)   state_d = ST_SETTLE;
				else                   state_d = ST_IDLE;
			end
			ST_INC_RD: state_d = ST_INC_WR;
			ST_INC_WR: begin
				if (!status.fin)       state_d = ST_IDLE;
				else if (closed_q)     state_d = ST_EMIT_RD;
				else                   state_d = ST_SETTLE;
			end
			ST_SETTLE: state_d = ST_FCLOSE;
			ST_FCLOSE: begin
				if (status.final_pending) state_d = ST_INC_RD;
				else                      state_d = ST_EMIT_RD;
			end
			ST_EMIT_RD: state_d = ST_EMIT_OUT;
			ST_EMIT_OUT: begin
				if (!out_stall) begin
					state_d = status.last_bin ? ST_IDLE : ST_EMIT_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands and handshake outputs.
	always_comb begin
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall     = 1'b0;
				cmd.load_hit = in_valid;
			end
			ST_EVAL: begin
				cmd.apply_hit = 1'b1;
				cmd.take_bin  = 1'b1;
			end
			ST_INC_RD: cmd.mem_rd = 1'b1;
			ST_INC_WR: cmd.mem_wr = 1'b1;
			ST_SETTLE: ;
			ST_FCLOSE: begin
				cmd.take_bin    = 1'b1;
				cmd.clear_group = 1'b1;
			end
			ST_EMIT_RD: begin
				cmd.mem_rd   = 1'b1;
				cmd.sel_emit = 1'b1;
			end
			ST_EMIT_OUT: begin
				out_valid     = 1'b1;
				cmd.sel_emit  = 1'b1;
				cmd.emit_next = !out_stall;
				cmd.emit_done = !out_stall && status.last_bin;
			end
			default: ;
		endcase
	end

endmodule

>>> design/cmh_checker.sv
// Port-level checker for the histogram block, bound to the top level.
module cmh_checker #(
	parameter int COUNT_BITS = cmh_pkg::COUNT_BITS_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [cmh_pkg::LEVEL_W-1:0] multiplicity_level,
	input logic [COUNT_BITS-1:0]       occurrence_count,
	input logic                        final_bin
);
	import cmh_pkg::*;

	// A stalled result transaction holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(multiplicity_level)
			&& $stable(occurrence_count) && $stable(final_bin))
		else $error("stalled result changed");

	// After a hit transaction the block is busy in the cycle after it.
	a_busy_after_hit: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("hit taken in consecutive cycles");

	// No hit is taken while a result is on offer.
	a_no_hit_during_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("hit channel open during emission");

	// A bin that is not the last is followed by a read cycle with nothing on offer.
	a_gap_between_bins: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !final_bin |=> !out_valid && in_stall)
		else $error("bins emitted back to back");

endmodule

bind coincidence_multiplicity_histogram cmh_checker #(
	.COUNT_BITS (COUNT_BITS)
) u_cmh_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_valid           (in_valid),
	.in_stall           (in_stall),
	.out_valid          (out_valid),
	.out_stall          (out_stall),
	.multiplicity_level (multiplicity_level),
	.occurrence_count   (occurrence_count),
	.final_bin          (final_bin)
);
